// ----- src/tcbe_pkg.sv -----
// Shared types and constants for the text cell buffer engine.
package tcbe_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int CELL_DEPTH_DEF  = 8192;

  // linear address arithmetic: (row 0..190) * (cols 0..255) + x + w fits in 17 bits
  localparam int LIN_W = 17;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [7:0] COLUMNS_RST    = 8'd80;
  localparam logic [6:0] ROWS_RST       = 7'd25;
  localparam logic [4:0] CURSOR_TOP_RST = 5'd0;

  typedef enum logic [1:0] {
    REG_COLUMNS       = 2'd0,
    REG_ROWS          = 2'd1,
    REG_CURSOR_TOP    = 2'd2,
    REG_CURSOR_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_PUT         = 3'd0,
    ACT_CLEAR       = 3'd1,
    ACT_SCROLL      = 3'd2,
    ACT_SET_CURSOR  = 3'd3,
    ACT_SET_VISIBLE = 3'd4,
    ACT_READ        = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_CHECK,
    ST_RDWAIT,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_t;

endpackage

// ----- src/text_cell_buffer_engine.sv -----
// Text cell buffer engine: cell store, region walker, cursor state.
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------------------------
//  request   start & !busy      action, col_x, row_y, region_width, region_height,
//                               char_code, fore_color, back_color, show_cursor
//  result    done (1 cycle)     ok, cell_value, cursor_pos, cursor_shape
//  config    cfg_we             cfg_index, cfg_data (no wait, no read-back)
//
// Steps: put, set cursor, set visibility, empty regions and failed requests end in
// the check state; read adds a wait state for the registered memory read. Clear
// walks the region in the fill state; scroll copies it up when h > 1 (one cell
// through the single write port per cycle, plus a drain state for the last copied
// cell) and then fills the bottom row, or fills only the bottom row when h is 1.
// Reset: the store is wiped one cell per cycle with busy high;
// configuration writes are taken throughout.
// The receiver cannot stall: each result transaction is shown for exactly one
// cycle, and a new request can be taken in that same cycle.
module text_cell_buffer_engine #(
  parameter int MAX_COLUMNS = tcbe_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tcbe_pkg::MAX_ROWS_DEF,
  parameter int CELL_DEPTH  = tcbe_pkg::CELL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [6:0]         col_x,
  input  logic [5:0]         row_y,
  input  logic [7:0]         region_width,
  input  logic [6:0]         region_height,
  input  logic [7:0]         char_code,
  input  logic [3:0]         fore_color,
  input  logic [3:0]         back_color,
  input  logic               show_cursor,
  input  logic               cfg_we,
  input  tcbe_pkg::cfg_reg_t cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               done,
  output logic               ok,
  output logic [15:0]        cell_value,
  output logic [12:0]        cursor_pos,
  output logic [5:0]         cursor_shape
);
  import tcbe_pkg::*;

  localparam int AW = $clog2(CELL_DEPTH);

  // cell store: one write and one registered read per cycle
  logic [15:0]   mem [CELL_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;
  logic [15:0]   rdata;

  state_t state, state_next;

  // configuration (cursor_bottom has no visible effect, so writes to it are dropped)
  logic [7:0] columns;
  logic [6:0] rows;
  logic [4:0] cursor_top;

  logic [12:0] cursor_location;
  logic        cursor_shown;

  // latched request
  action_t    req_act;
  logic [6:0] req_x;
  logic [5:0] req_y;
  logic [7:0] req_w;
  logic [6:0] req_h;
  logic [7:0] req_char;
  logic [3:0] req_fg;
  logic [3:0] req_bg;
  logic       req_show;

  // region walker
  logic [AW-1:0] cur_addr;   // also the wipe counter after reset
  logic [AW-1:0] line_addr;
  logic [AW-1:0] fill_start;
  logic [AW-1:0] pend_addr;
  logic          pend_v;
  logic [7:0]    col_cnt;
  logic [6:0]    rows_left;

  // geometry checks
  logic [7:0]       c_eff;
  logic [6:0]       r_eff;
  logic [7:0]       geo_w;
  logic [6:0]       geo_h;
  logic [8:0]       x_end;
  logic [7:0]       y_end;
  logic [7:0]       last_row;
  logic [15:0]      last_prod, base_prod;
  logic [LIN_W-1:0] last_row_start, last_addr, row_base;
  logic             in_screen, is_empty, in_store, fits;
  logic             walk_last_col, walk_last_line, walk_end;

  logic        finish;
  logic        fin_ok;
  logic [15:0] fin_value;

  assign busy         = (state != ST_IDLE);
  assign cursor_pos   = cursor_location;
  assign cursor_shape = {~cursor_shown, cursor_top};

  always_comb begin
    c_eff = ({1'b0, columns} > 9'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : columns;
    r_eff = ({1'b0, rows} > 8'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows;
    // single-cell actions check a 1x1 region
    if (req_act == ACT_CLEAR || req_act == ACT_SCROLL) begin
      geo_w = req_w;
      geo_h = req_h;
    end else begin
      geo_w = 8'd1;
      geo_h = 7'd1;
    end
    x_end          = {2'b00, req_x} + {1'b0, geo_w};
    y_end          = {2'b00, req_y} + {1'b0, geo_h};
    in_screen      = (x_end <= {1'b0, c_eff}) && (y_end <= {1'b0, r_eff});
    is_empty       = (geo_w == 8'd0) || (geo_h == 7'd0);
    last_row       = y_end - 8'd1;
    last_prod      = last_row * c_eff;
    base_prod      = {2'b00, req_y} * c_eff;
    last_row_start = LIN_W'(last_prod) + LIN_W'(req_x);
    last_addr      = last_row_start + LIN_W'(geo_w) - LIN_W'(1);
    in_store       = last_addr < LIN_W'(CELL_DEPTH);
    fits           = in_screen && (is_empty || in_store);
    row_base       = LIN_W'(base_prod) + LIN_W'(req_x);
  end

  assign walk_last_col  = (col_cnt == req_w - 8'd1);
  assign walk_last_line = (rows_left == 7'd1);
  assign walk_end       = walk_last_col && walk_last_line;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE:   if (cur_addr == AW'(CELL_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = ST_IDLE;
        if (fits) begin
          unique case (req_act)
            ACT_READ:   state_next = ST_RDWAIT;
            ACT_CLEAR:  if (!is_empty) state_next = ST_FILL;
            ACT_SCROLL: if (!is_empty) state_next = (req_h > 7'd1) ? ST_COPY : ST_FILL;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_RDWAIT: state_next = ST_IDLE;
      ST_COPY:   if (walk_end) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FILL;
      ST_FILL:   if (walk_end) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = cur_addr;
    mem_wd    = {req_bg, req_fg, SPACE_CHAR};
    mem_re    = 1'b0;
    mem_ra    = cur_addr;
    finish    = 1'b0;
    fin_ok    = 1'b0;
    fin_value = 16'd0;
    unique case (state)
      ST_WIPE: begin
        mem_we = 1'b1;
        mem_wd = 16'd0;
      end
      ST_CHECK: begin
        finish = 1'b1;
        unique case (req_act)
          ACT_PUT: begin
            fin_ok = fits;
            mem_we = fits;
            mem_wa = row_base[AW-1:0];
            mem_wd = {req_bg, req_fg, req_char};
          end
          ACT_READ: begin
            mem_re = fits;
            mem_ra = row_base[AW-1:0];
            finish = !fits;
          end
          ACT_CLEAR, ACT_SCROLL: begin
            fin_ok = fits;
            finish = !(fits && !is_empty);
          end
          ACT_SET_CURSOR:  fin_ok = in_screen;
          ACT_SET_VISIBLE: fin_ok = 1'b1;
          default:         fin_ok = 1'b0;
        endcase
      end
      ST_RDWAIT: begin
        finish    = 1'b1;
        fin_ok    = 1'b1;
        fin_value = rdata;
      end
      ST_COPY: begin
        // read row i, write the previous read one row up
        mem_re = 1'b1;
        mem_we = pend_v;
        mem_wa = pend_addr;
        mem_wd = rdata;
      end
      ST_DRAIN: begin
        mem_we = pend_v;
        mem_wa = pend_addr;
        mem_wd = rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        finish = walk_end;
        fin_ok = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_WIPE;
      cur_addr        <= '0;
      done            <= 1'b0;
      pend_v          <= 1'b0;
      cursor_location <= 13'd0;
      cursor_shown    <= 1'b1;
      columns         <= COLUMNS_RST;
      rows            <= ROWS_RST;
      cursor_top      <= CURSOR_TOP_RST;
    end else begin
      state <= state_next;
      done  <= finish;
      if (finish) begin
        ok         <= fin_ok;
        cell_value <= fin_value;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMNS:       columns    <= cfg_data;
          REG_ROWS:          rows       <= cfg_data[6:0];
          REG_CURSOR_TOP:    cursor_top <= cfg_data[4:0];
          REG_CURSOR_BOTTOM: ;
        endcase
      end

      unique case (state)
        ST_WIPE: cur_addr <= cur_addr + AW'(1);
        ST_IDLE: begin
          if (start) begin
            req_act  <= action_t'(action);
            req_x    <= col_x;
            req_y    <= row_y;
            req_w    <= region_width;
            req_h    <= region_height;
            req_char <= char_code;
            req_fg   <= fore_color;
            req_bg   <= back_color;
            req_show <= show_cursor;
          end
        end
        ST_CHECK: begin
          col_cnt    <= 8'd0;
          fill_start <= last_row_start[AW-1:0];
          if (req_act == ACT_SET_CURSOR && in_screen) cursor_location <= row_base[12:0];
          if (req_act == ACT_SET_VISIBLE) cursor_shown <= req_show;
          if (req_act == ACT_SCROLL) begin
            if (req_h > 7'd1) begin
              // copy source starts one row below the top edge
              cur_addr  <= row_base[AW-1:0] + AW'(c_eff);
              line_addr <= row_base[AW-1:0] + AW'(c_eff);
              rows_left <= req_h - 7'd1;
            end else begin
              cur_addr  <= last_row_start[AW-1:0];
              line_addr <= last_row_start[AW-1:0];
              rows_left <= 7'd1;
            end
          end else begin
            cur_addr  <= row_base[AW-1:0];
            line_addr <= row_base[AW-1:0];
            rows_left <= req_h;
          end
        end
        ST_COPY, ST_FILL: begin
          if (state == ST_COPY) begin
            pend_addr <= cur_addr - AW'(c_eff);
            pend_v    <= 1'b1;
          end
          if (walk_last_col) begin
            col_cnt   <= 8'd0;
            line_addr <= line_addr + AW'(c_eff);
            cur_addr  <= line_addr + AW'(c_eff);
            rows_left <= rows_left - 7'd1;
          end else begin
            col_cnt  <= col_cnt + 8'd1;
            cur_addr <= cur_addr + AW'(1);
          end
        end
        ST_DRAIN: begin
          // bottom row of the region gets blanks
          pend_v    <= 1'b0;
          cur_addr  <= fill_start;
          line_addr <= fill_start;
          rows_left <= 7'd1;
          col_cnt   <= 8'd0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/tb_text_cell_buffer_engine.sv -----
// Self-checking testbench for the text cell buffer engine: directed script, random phases.
module tb_text_cell_buffer_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import tcbe_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int MAX_COLUMNS   = MAX_COLUMNS_DEF;
  localparam int MAX_ROWS      = MAX_ROWS_DEF;
  localparam int CELL_DEPTH    = CELL_DEPTH_DEF;
  // Slowest run here: the reset wipe, a handful of full-store clears and scrolls
  // and some 750 short transactions with sender gaps; the limit leaves ample
  // headroom for all of it.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 120;
  // Transactions in this window go out back to back, with no sender gaps.
  localparam int CALM_FIRST    = 300;
  localparam int CALM_LAST     = 420;
  localparam int GAP_PERCENT   = 25;

  localparam logic [4:0] CURSOR_BOTTOM_RST = 5'd15;
  // Action codes the block does not implement; they must fail quietly.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] act;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] w;
    logic [6:0] h;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       show;
  } cell_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] cell_word;
    logic [12:0] pos;
    logic [5:0]  shape;
  } cell_rsp_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  // One line of the directed script: either a register write or a request,
  // optionally with its result typed in by hand.
  typedef struct packed {
    row_kind_t  kind;
    cfg_reg_t   reg_index;
    logic [7:0] reg_value;
    cell_req_t  rq;
    logic       typed;
    cell_rsp_t  want;
  } script_row_t;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [6:0]  col_x;
  logic [5:0]  row_y;
  logic [7:0]  region_width;
  logic [6:0]  region_height;
  logic [7:0]  char_code;
  logic [3:0]  fore_color;
  logic [3:0]  back_color;
  logic        show_cursor;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic        ok;
  logic [15:0] cell_value;
  logic [12:0] cursor_pos;
  logic [5:0]  cursor_shape;

  text_cell_buffer_engine i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .col_x         (col_x),
    .row_y         (row_y),
    .region_width  (region_width),
    .region_height (region_height),
    .char_code     (char_code),
    .fore_color    (fore_color),
    .back_color    (back_color),
    .show_cursor   (show_cursor),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .ok            (ok),
    .cell_value    (cell_value),
    .cursor_pos    (cursor_pos),
    .cursor_shape  (cursor_shape)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block's state, advanced at each accepted transaction
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_cells [CELL_DEPTH];
  logic [12:0] shadow_cursor;
  logic        shadow_shown;
  logic [7:0]  geo_cols;
  logic [6:0]  geo_rows;
  logic [4:0]  shape_top;
  logic [4:0]  shape_bottom;   // written to the block but dropped there; never visible

  cell_rsp_t   pending_outcomes[$];
  script_row_t script[$];
  int          fault_count = 0;
  int          sent_items  = 0;
  int          cycle_count = 0;

  // Geometry beyond the store's limits is clamped, not rejected.
  function automatic int eff_columns();
    return (geo_cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(geo_cols);
  endfunction

  function automatic int eff_rows();
    return (geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows);
  endfunction

  // Rectangle must sit on screen; an empty one is fine as long as its corner is.
  function automatic bit region_on_screen(int x, int y, int w, int h);
    int c;
    c = eff_columns();
    if (x + w > c || y + h > eff_rows()) return 1'b0;
    if (w == 0 || h == 0) return 1'b1;
    return (y + h - 1) * c + x + w - 1 < CELL_DEPTH;
  endfunction

  // Carries out one request on the shadow state and returns what the block
  // should report for it.
  function automatic cell_rsp_t carry_out_action(cell_req_t rq);
    int          c, x, y, w, h, i, j, lin;
    logic [15:0] blank;
    cell_rsp_t   o;
    c     = eff_columns();
    x     = int'(rq.x);
    y     = int'(rq.y);
    w     = int'(rq.w);
    h     = int'(rq.h);
    blank = {rq.bg, rq.fg, SPACE_CHAR};
    o     = '0;
    case (rq.act)
      ACT_PUT: begin
        if (region_on_screen(x, y, 1, 1)) begin
          shadow_cells[y * c + x] = {rq.bg, rq.fg, rq.ch};
          o.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        if (region_on_screen(x, y, w, h)) begin
          for (i = 0; i < h; i++)
            for (j = 0; j < w; j++)
              shadow_cells[(y + i) * c + x + j] = blank;
          o.ok = 1'b1;
        end
      end
      ACT_SCROLL: begin
        if (region_on_screen(x, y, w, h)) begin
          if (h > 0) begin
            for (i = 1; i < h; i++)
              for (j = 0; j < w; j++)
                shadow_cells[(y + i - 1) * c + x + j] = shadow_cells[(y + i) * c + x + j];
            for (j = 0; j < w; j++)
              shadow_cells[(y + h - 1) * c + x + j] = blank;
          end
          o.ok = 1'b1;
        end
      end
      ACT_SET_CURSOR: begin
        if (x < c && y < eff_rows()) begin
          lin           = y * c + x;
          shadow_cursor = lin[12:0];
          o.ok          = 1'b1;
        end
      end
      ACT_SET_VISIBLE: begin
        shadow_shown = rq.show;
        o.ok         = 1'b1;
      end
      ACT_READ: begin
        if (region_on_screen(x, y, 1, 1)) begin
          o.cell_word = shadow_cells[y * c + x];
          o.ok        = 1'b1;
        end
      end
      default: ;
    endcase
    o.pos   = shadow_cursor;
    o.shape = {~shadow_shown, shape_top};
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Script construction helpers
  // ---------------------------------------------------------------------------
  function automatic cell_req_t mk_req(logic [2:0] act, int x, int y, int w, int h,
                                       logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                                       logic show);
    cell_req_t rq;
    rq.act  = act;
    rq.x    = 7'(x);
    rq.y    = 6'(y);
    rq.w    = 8'(w);
    rq.h    = 7'(h);
    rq.ch   = ch;
    rq.fg   = fg;
    rq.bg   = bg;
    rq.show = show;
    return rq;
  endfunction

  function automatic cell_rsp_t mk_rsp(logic okay, logic [15:0] cell_word, logic [12:0] pos,
                                       logic [5:0] shape);
    cell_rsp_t r;
    r.ok        = okay;
    r.cell_word = cell_word;
    r.pos       = pos;
    r.shape     = shape;
    return r;
  endfunction

  function automatic script_row_t request_row(cell_req_t rq);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_REQUEST;
    row.rq    = rq;
    return row;
  endfunction

  function automatic script_row_t checked_row(cell_req_t rq, cell_rsp_t want);
    script_row_t row;
    row       = request_row(rq);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic script_row_t register_row(cfg_reg_t idx, logic [7:0] val);
    script_row_t row;
    row           = '0;
    row.kind      = ROW_REGISTER;
    row.reg_index = idx;
    row.reg_value = val;
    return row;
  endfunction

  // Mostly well-formed requests, half of them near the origin so that reads
  // land on cells written earlier; the rest is full-range noise that mostly fails.
  function automatic cell_req_t random_request();
    int        c, rr, pick, xs, ys;
    cell_req_t rq;
    c       = eff_columns();
    rr      = eff_rows();
    rq.x    = 7'($urandom_range(0, 127));
    rq.y    = 6'($urandom_range(0, 63));
    rq.w    = 8'($urandom_range(0, 255));
    rq.h    = 7'($urandom_range(0, 127));
    rq.ch   = 8'($urandom_range(0, 255));
    rq.fg   = 4'($urandom_range(0, 15));
    rq.bg   = 4'($urandom_range(0, 15));
    rq.show = 1'($urandom_range(0, 1));
    pick    = $urandom_range(0, 99);
    if (pick < 28)      rq.act = ACT_PUT;
    else if (pick < 50) rq.act = ACT_READ;
    else if (pick < 62) rq.act = ACT_CLEAR;
    else if (pick < 74) rq.act = ACT_SCROLL;
    else if (pick < 86) rq.act = ACT_SET_CURSOR;
    else if (pick < 95) rq.act = ACT_SET_VISIBLE;
    else                rq.act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    if (c > 0 && rr > 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 1)) begin
        xs = (c < 16) ? c : 16;
        ys = (rr < 8) ? rr : 8;
      end else begin
        xs = c;
        ys = rr;
      end
      rq.x = 7'($urandom_range(0, xs - 1));
      rq.y = 6'($urandom_range(0, ys - 1));
      // the odd region runs to the screen edge; most stay tiny to keep runtime down
      if ($urandom_range(0, 99) < 3) begin
        rq.w = 8'($urandom_range(0, c - rq.x));
        rq.h = 7'($urandom_range(0, rr - rq.y));
      end else begin
        rq.w = 8'($urandom_range(0, (c - rq.x < 6) ? c - rq.x : 6));
        rq.h = 7'($urandom_range(0, (rr - rq.y < 4) ? rr - rq.y : 4));
      end
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks (called at a rising edge, drive with NBAs)
  // ---------------------------------------------------------------------------

  // Drops start and waits until every transaction has reported back and the
  // block is idle; returns at a rising edge. Checked at the falling edge so
  // the result strobe and the queue pop have settled.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_outcomes.size() != 0 || busy);
    @(posedge clk);
  endtask

  // Random sender gaps, skipped inside the calm window.
  task automatic sender_gap();
    if (sent_items >= CALM_FIRST && sent_items < CALM_LAST) return;
    while ($urandom_range(0, 99) < GAP_PERCENT) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One register write, then the enable is dropped before returning, so back-to-back writes never
  // lower and raise the enable within the same step.
  task automatic write_register(cfg_reg_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_COLUMNS:       geo_cols     = val;
      REG_ROWS:          geo_rows     = val[6:0];
      REG_CURSOR_TOP:    shape_top    = val[4:0];
      REG_CURSOR_BOTTOM: shape_bottom = val[4:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Presents a request and holds it until the edge that accepts it; start is
  // left high so the next transaction can follow without a gap.
  task automatic send_request(cell_req_t rq, logic typed, cell_rsp_t want);
    cell_rsp_t predicted;
    start         <= 1'b1;
    action        <= rq.act;
    col_x         <= rq.x;
    row_y         <= rq.y;
    region_width  <= rq.w;
    region_height <= rq.h;
    char_code     <= rq.ch;
    fore_color    <= rq.fg;
    back_color    <= rq.bg;
    show_cursor   <= rq.show;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: update the shadow and queue the outcome
    predicted = carry_out_action(rq);
    pending_outcomes.push_back(typed ? want : predicted);
    sent_items++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobed result is matched against the oldest outcome
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    cell_rsp_t got, want;
    if (!rst && done) begin
      got.ok        = ok;
      got.cell_word = cell_value;
      got.pos       = cursor_pos;
      got.shape     = cursor_shape;
      if (pending_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with no transaction outstanding: ok=%0b cell=%h pos=%0d shape=%h",
                   $realtime, got.ok, got.cell_word, got.pos, got.shape);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.ok !== want.ok || got.cell_word !== want.cell_word ||
            got.pos !== want.pos || got.shape !== want.shape) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch, expected ok=%0b cell=%h pos=%0d shape=%h",
                     $realtime, want.ok, want.cell_word, want.pos, want.shape);
            $display("%0t:                   actual  ok=%0b cell=%h pos=%0d shape=%h",
                     $realtime, got.ok, got.cell_word, got.pos, got.shape);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_text_cell_buffer_engine NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t row;
    int          cols, rws;

    // everything known from time zero
    rst           = 1'b1;
    start         = 1'b0;
    action        = ACT_PUT;
    col_x         = '0;
    row_y         = '0;
    region_width  = '0;
    region_height = '0;
    char_code     = '0;
    fore_color    = '0;
    back_color    = '0;
    show_cursor   = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_COLUMNS;
    cfg_data      = '0;

    // shadow state as after reset: store blank, cursor home and visible
    foreach (shadow_cells[k]) shadow_cells[k] = '0;
    shadow_cursor = '0;
    shadow_shown  = 1'b1;
    geo_cols      = COLUMNS_RST;
    geo_rows      = ROWS_RST;
    shape_top     = CURSOR_TOP_RST;
    shape_bottom  = CURSOR_BOTTOM_RST;

    // Directed script. Default 80x25 screen first: reads after reset, the
    // far corner, out-of-range cells, spare actions and the hide bit.
    script.push_back(checked_row(mk_req(ACT_READ, 0, 0, 0, 0, 8'h00, 0, 0, 0),
                                 mk_rsp(1'b1, 16'h0000, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_PUT, 79, 24, 0, 0, 8'hFF, 15, 15, 1),
                                 mk_rsp(1'b1, 16'h0000, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_READ, 79, 24, 0, 0, 8'h00, 0, 0, 0),
                                 mk_rsp(1'b1, 16'hFFFF, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_PUT, 80, 0, 0, 0, 8'h41, 1, 1, 0),
                                 mk_rsp(1'b0, 16'h0000, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_READ, 0, 25, 0, 0, 8'h00, 0, 0, 0),
                                 mk_rsp(1'b0, 16'h0000, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_SPARE_HI, 0, 0, 1, 1, 8'h00, 0, 0, 1),
                                 mk_rsp(1'b0, 16'h0000, 13'd0, 6'h00)));
    script.push_back(checked_row(mk_req(ACT_SET_VISIBLE, 0, 0, 0, 0, 8'h00, 0, 0, 0),
                                 mk_rsp(1'b1, 16'h0000, 13'd0, 6'h20)));
    script.push_back(checked_row(mk_req(ACT_SET_VISIBLE, 0, 0, 0, 0, 8'h00, 0, 0, 1),
                                 mk_rsp(1'b1, 16'h0000, 13'd0, 6'h00)));
    // full-screen clear, a marker, full-screen scroll, then look where it went
    script.push_back(request_row(mk_req(ACT_SET_CURSOR, 79, 24, 0, 0, 8'h00, 0, 0, 0)));
    script.push_back(request_row(mk_req(ACT_CLEAR, 0, 0, 80, 25, 8'h00, 1, 2, 0)));
    script.push_back(request_row(mk_req(ACT_PUT, 5, 5, 0, 0, 8'h41, 14, 1, 0)));
    script.push_back(request_row(mk_req(ACT_SCROLL, 0, 0, 80, 25, 8'h00, 3, 4, 0)));
    script.push_back(request_row(mk_req(ACT_READ, 5, 4, 0, 0, 8'h00, 0, 0, 0)));
    // empty regions succeed, overhanging ones fail
    script.push_back(request_row(mk_req(ACT_SCROLL, 10, 3, 10, 0, 8'h00, 6, 7, 0)));
    script.push_back(request_row(mk_req(ACT_CLEAR, 0, 0, 0, 5, 8'h00, 8, 9, 0)));
    script.push_back(request_row(mk_req(ACT_CLEAR, 70, 20, 11, 1, 8'h00, 1, 1, 0)));
    script.push_back(request_row(mk_req(ACT_SCROLL, 0, 24, 1, 2, 8'h00, 1, 1, 0)));
    // zero-sized screen: only an empty region at the origin gets through
    script.push_back(register_row(REG_COLUMNS, 8'd0));
    script.push_back(register_row(REG_ROWS, 8'd0));
    script.push_back(request_row(mk_req(ACT_PUT, 0, 0, 0, 0, 8'h55, 5, 5, 0)));
    script.push_back(request_row(mk_req(ACT_CLEAR, 0, 0, 0, 0, 8'h00, 2, 2, 0)));
    script.push_back(request_row(mk_req(ACT_SET_CURSOR, 0, 0, 0, 0, 8'h00, 0, 0, 0)));
    // oversized geometry clamps to the full store; top scan line at its maximum
    script.push_back(register_row(REG_COLUMNS, 8'd255));
    script.push_back(register_row(REG_ROWS, 8'd127));
    script.push_back(register_row(REG_CURSOR_TOP, 8'd31));
    script.push_back(register_row(REG_CURSOR_BOTTOM, 8'd0));
    script.push_back(request_row(mk_req(ACT_PUT, 127, 63, 0, 0, 8'h00, 0, 15, 0)));
    script.push_back(request_row(mk_req(ACT_READ, 127, 63, 0, 0, 8'h00, 0, 0, 0)));
    script.push_back(request_row(mk_req(ACT_SET_CURSOR, 127, 63, 0, 0, 8'h00, 0, 0, 0)));
    script.push_back(request_row(mk_req(ACT_CLEAR, 0, 0, 128, 64, 8'h00, 5, 10, 0)));
    script.push_back(request_row(mk_req(ACT_SCROLL, 0, 0, 128, 64, 8'h00, 15, 0, 1)));

    // reset, then sit out the store wipe
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    foreach (script[n]) begin
      row = script[n];
      if (row.kind == ROW_REGISTER) begin
        wait_idle();
        write_register(row.reg_index, row.reg_value);
      end else begin
        sender_gap();
        send_request(row.rq, row.typed, row.want);
      end
    end

    // Random phases, each on its own screen geometry and cursor shape
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          cols = 1;
          rws  = 1;
        end
        1: begin
          cols = MAX_COLUMNS;
          rws  = MAX_ROWS;
        end
        2: begin
          cols = $urandom_range(MAX_COLUMNS + 1, 255);
          rws  = $urandom_range(MAX_ROWS + 1, 127);
        end
        3: begin
          cols = COLUMNS_RST;
          rws  = ROWS_RST;
        end
        default: begin
          cols = $urandom_range(1, MAX_COLUMNS);
          rws  = $urandom_range(1, MAX_ROWS);
        end
      endcase
      wait_idle();
      write_register(REG_COLUMNS, 8'(cols));
      write_register(REG_ROWS, 8'(rws));
      write_register(REG_CURSOR_TOP, 8'($urandom_range(0, 31)));
      write_register(REG_CURSOR_BOTTOM, 8'($urandom_range(0, 31)));
      repeat (PHASE_ITEMS) begin
        sender_gap();
        send_request(random_request(), 1'b0, '0);
      end
    end

    // drain: every outcome back, then an idle wait for stray strobes
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb_text_cell_buffer_engine OK");
    end else begin
      $display("tb_text_cell_buffer_engine NOT OK");
    end
    $finish;
  end

endmodule

// ----- text_cell_buffer_engine.f -----
src/tcbe_pkg.sv
src/text_cell_buffer_engine.sv
verif/tb_text_cell_buffer_engine.sv
